// File: rtl/core/chained_chunk_allocator_core_assert.svh
// Assertion macros used by the checker file cca_checker.sv.
`ifndef CHAINED_CHUNK_ALLOCATOR_CORE_ASSERT_SVH
`define CHAINED_CHUNK_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CCA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg
// Types, codes and constants of the chained chunk allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package cca_pkg;

  localparam int CHUNK_BYTES = 1024;
  localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int POOL_CHUNKS = 4096;
  localparam int CADDR_W     = $clog2(POOL_CHUNKS);
  localparam int MAX_CHAIN   = 64;
  localparam int KEY_SLOTS   = 64;

  // Command codes
  localparam logic [1:0] CMD_HAS = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_SET = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_KEYS_FULL = 2'd2;
  localparam logic [1:0] ST_NO_CHUNKS = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [16:0] length;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [12:0] chunk_index;
    logic [10:0] used_size;
    logic [21:0] byte_offset;
    logic        last;
  } out_word_t;

  // One chunk's link and fill
  typedef struct packed {
    logic [12:0] next;
    logic [10:0] used;
  } chunk_word_t;

  // One key slot
  typedef struct packed {
    logic [63:0] key;
    logic [12:0] head;
    logic [6:0]  len;
  } slot_word_t;

  // Outcome of a key table scan
  typedef struct packed {
    logic        done;
    logic        hit;
    logic        free_ok;
    logic [12:0] head;
    logic [6:0]  len;
  } scan_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_B_STEP, S_B_WAIT, S_B_FIN, S_F_STEP, S_F_WAIT,
    S_SLOT, S_E_RD, S_E_OUT
  } state_t;

  // Chunk number 1..POOL_CHUNKS to RAM address
  function automatic logic [CADDR_W-1:0] chunk_addr(input logic [12:0] c);
    logic [12:0] t;
    t = c - 13'd1;
    return t[CADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/chained_chunk_allocator_core.sv
// ----------------------------------------------------------------------------
// chained_chunk_allocator_core
// Keyed chunk-chain manager: has, get and set on chains of pool chunks.
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start; the word is taken at a clock edge
// where start is high and busy is low. busy stays high until the final
// result of the word has been put out.
// Results appear on out_data for one cycle each, marked by out_strobe; the
// final one carries last. The receiver cannot stall, so results come at the
// pace of the sequencer.
// Flow: every command first scans all KEY_SLOTS key slots, one per cycle,
// which holds the sequencer; a has then gives its one result. A failed get
// or set, or an empty chain, likewise gives one result. A get emits its
// chain chunk by chunk, walking the link RAM. A set builds the chain (a RAM
// read per reused or recycled chunk), frees the old tail, then emits as a
// get. The link RAM has one read and one write port and a registered
// read.
// Reset clears the key valid bits and the free list counters; the memories
// need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_chunk_allocator_core #(
  parameter int KEY_SLOTS = cca_pkg::KEY_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cca_pkg::in_word_t  in_data,
  output logic               out_strobe,
  output cca_pkg::out_word_t out_data
);
  import cca_pkg::*;

  localparam int SLOT_W = $clog2(KEY_SLOTS);

  state_t state_r, state_nxt;
  logic [1:0]  cmd_r;
  logic [63:0] key_r;
  logic [16:0] len_r;
  logic [7:0]  n_r, n_nxt;
  logic [6:0]  lim_r, lim_nxt;
  logic [6:0]  i_r, i_nxt;
  logic [12:0] cur_r, cur_nxt;
  logic [12:0] prev_r, prev_nxt;
  logic [12:0] head_new_r, head_new_nxt;
  logic        src_old_r, src_old_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [12:0] free_head_r, free_head_nxt;
  logic [12:0] fresh_r, fresh_nxt;
  logic [12:0] fcnt_r, fcnt_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic        out_strobe_r, out_strobe_nxt;
  out_word_t   out_r, out_nxt;

  logic        scan_start;
  scan_res_t   scan;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic        slot_we;
  slot_word_t  slot_wdata;

  logic        ram_we;
  logic [CADDR_W-1:0] ram_waddr, ram_raddr;
  chunk_word_t ram_wdata, ram_rdata;

  logic [17:0] n_sum;
  logic [7:0]  n_calc;
  logic [10:0] last_used;
  logic [6:0]  found_lim;
  logic [12:0] c_sel;
  logic [7:0]  need;

  cca_key_table #(.KEY_SLOTS(KEY_SLOTS), .SLOT_W(SLOT_W)) u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan_start(scan_start),
    .key       (key_r),
    .wr_en     (slot_we),
    .wr_idx    (slot_r),
    .wr_data   (slot_wdata),
    .res       (scan),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx)
  );

  cca_chunk_ram u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Chunk count and final fill of the requested length
  assign n_sum     = {1'b0, len_r} + 18'(CHUNK_BYTES - 1);
  assign n_calc    = n_sum[CHUNK_SHIFT+7:CHUNK_SHIFT];
  assign last_used = (len_r[CHUNK_SHIFT-1:0] == '0) ? 11'(CHUNK_BYTES)
                                                    : 11'(len_r[CHUNK_SHIFT-1:0]);
  assign found_lim = (scan.len > 7'(MAX_CHAIN)) ? 7'(MAX_CHAIN) : scan.len;
  assign c_sel     = ({1'b0, i_r} < {1'b0, lim_r}) ? cur_r :
                     (free_head_r != '0) ? free_head_r : fresh_r;
  assign need      = n_calc - {1'b0, found_lim};

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= in_data.cmd;
      key_r <= in_data.key;
      len_r <= in_data.length;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= '0;
      fresh_r      <= 13'd1;
      fcnt_r       <= 13'(POOL_CHUNKS);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      fresh_r      <= fresh_nxt;
      fcnt_r       <= fcnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    lim_r      <= lim_nxt;
    i_r        <= i_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    head_new_r <= head_new_nxt;
    src_old_r  <= src_old_nxt;
    slot_r     <= slot_nxt;
    rem_r      <= rem_nxt;
    out_r      <= out_nxt;
  end

  // Next state and control
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    lim_nxt        = lim_r;
    i_nxt          = i_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    head_new_nxt   = head_new_r;
    src_old_nxt    = src_old_r;
    slot_nxt       = slot_r;
    free_head_nxt  = free_head_r;
    fresh_nxt      = fresh_r;
    fcnt_nxt       = fcnt_r;
    rem_nxt        = rem_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    scan_start     = 1'b0;
    slot_we        = 1'b0;
    slot_wdata     = '{key: key_r, head: head_new_r, len: n_r[6:0]};
    ram_we         = 1'b0;
    ram_waddr      = chunk_addr(prev_r);
    ram_wdata      = '{next: c_sel, used: 11'(CHUNK_BYTES)};
    ram_raddr      = chunk_addr(cur_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          scan_start = 1'b1;
          state_nxt  = S_SCAN;
        end
      end

      // Wait for the scan, then settle the command
      S_SCAN: begin
        if (scan.done) begin
          out_nxt   = '0;
          out_nxt.last = 1'b1;
          n_nxt     = n_calc;
          i_nxt     = '0;
          cur_nxt   = scan.head;
          rem_nxt   = scan.len;
          state_nxt = S_IDLE;
          unique case (cmd_r)
            CMD_HAS: begin
              out_nxt.found  = scan.hit;
              out_strobe_nxt = 1'b1;
            end
            CMD_GET: begin
              if (!scan.hit) begin
                out_nxt.status = ST_NOT_FOUND;
                out_strobe_nxt = 1'b1;
              end else if (scan.len == '0 || scan.len > 7'(MAX_CHAIN)) begin
                out_strobe_nxt = 1'b1;
              end else begin
                state_nxt = S_E_RD;
              end
            end
            CMD_SET: begin
              lim_nxt  = scan.hit ? found_lim : '0;
              slot_nxt = scan.hit ? hit_idx : free_idx;
              if (!scan.hit && !scan.free_ok) begin
                out_nxt.status = ST_KEYS_FULL;
                out_strobe_nxt = 1'b1;
              end else if (n_calc > 8'(MAX_CHAIN) ||
                           (scan.hit && n_calc > {1'b0, found_lim} &&
                            {5'b0, need} > fcnt_r) ||
                           (!scan.hit && {5'b0, n_calc} > fcnt_r)) begin
                out_nxt.status = ST_NO_CHUNKS;
                out_strobe_nxt = 1'b1;
              end else if (n_calc == '0) begin
                state_nxt = S_B_FIN;
              end else begin
                state_nxt = S_B_STEP;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      // Pick the chunk for place i and link the previous one to it
      S_B_STEP: begin
        if (i_r != '0) begin
          ram_we = 1'b1;
        end else begin
          head_new_nxt = c_sel;
        end
        prev_nxt  = c_sel;
        i_nxt     = i_r + 7'd1;
        ram_raddr = chunk_addr(c_sel);
        if (i_r < lim_r) begin
          src_old_nxt = 1'b1;
          state_nxt   = S_B_WAIT;
        end else begin
          fcnt_nxt = fcnt_r - 13'd1;
          if (free_head_r != '0) begin
            src_old_nxt = 1'b0;
            state_nxt   = S_B_WAIT;
          end else begin
            fresh_nxt = fresh_r + 13'd1;
            state_nxt = ({1'b0, i_r} + 8'd1 == n_r) ? S_B_FIN : S_B_STEP;
          end
        end
      end

      // Advance the old chain or pop the free list
      S_B_WAIT: begin
        if (src_old_r) begin
          cur_nxt = ram_rdata.next;
        end else begin
          free_head_nxt = ram_rdata.next;
        end
        state_nxt = ({1'b0, i_r} == n_r) ? S_B_FIN : S_B_STEP;
      end

      // Close the chain
      S_B_FIN: begin
        if (n_r != '0) begin
          ram_we    = 1'b1;
          ram_wdata = '{next: 13'd0, used: last_used};
        end
        state_nxt = S_F_STEP;
      end

      // Free the old tail in chain order
      S_F_STEP: begin
        state_nxt = (i_r < lim_r) ? S_F_WAIT : S_SLOT;
      end

      S_F_WAIT: begin
        ram_we        = 1'b1;
        ram_waddr     = chunk_addr(cur_r);
        ram_wdata     = '{next: free_head_r, used: 11'd0};
        free_head_nxt = cur_r;
        fcnt_nxt      = fcnt_r + 13'd1;
        cur_nxt       = ram_rdata.next;
        i_nxt         = i_r + 7'd1;
        state_nxt     = S_F_STEP;
      end

      // Store the slot, then list the chain, or give one empty result if it has none
      S_SLOT: begin
        slot_we = 1'b1;
        if (n_r == '0) begin
          slot_wdata.head = '0;
          out_nxt         = '0;
          out_nxt.last    = 1'b1;
          out_strobe_nxt  = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cur_nxt   = head_new_r;
          rem_nxt   = n_r[6:0];
          state_nxt = S_E_RD;
        end
      end

      S_E_RD: begin
        state_nxt = S_E_OUT;
      end

      // Emit one chunk and follow its link
      S_E_OUT: begin
        out_nxt.status      = ST_OK;
        out_nxt.found       = 1'b0;
        out_nxt.chunk_index = cur_r;
        out_nxt.used_size   = ram_rdata.used;
        out_nxt.byte_offset = 22'({9'd0, cur_r - 13'd1} << CHUNK_SHIFT);
        out_nxt.last        = (rem_r == 7'd1);
        out_strobe_nxt      = 1'b1;
        cur_nxt             = ram_rdata.next;
        rem_nxt             = rem_r - 7'd1;
        state_nxt           = (rem_r == 7'd1) ? S_IDLE : S_E_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;
endmodule
`default_nettype wire

// File: rtl/core/cca_chunk_ram.sv
// ----------------------------------------------------------------------------
// cca_chunk_ram
// Link and fill memory of the chunk pool, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none
module cca_chunk_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [cca_pkg::CADDR_W-1:0] waddr,
  input  cca_pkg::chunk_word_t       wdata,
  input  logic [cca_pkg::CADDR_W-1:0] raddr,
  output cca_pkg::chunk_word_t       rdata
);
  import cca_pkg::*;

  chunk_word_t mem [POOL_CHUNKS];
  chunk_word_t rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// File: rtl/core/cca_key_table.sv
// ----------------------------------------------------------------------------
// cca_key_table
// Key slot memory with valid bits; scans all slots one per cycle for a key.
// ----------------------------------------------------------------------------
`default_nettype none
module cca_key_table #(
  parameter int KEY_SLOTS = cca_pkg::KEY_SLOTS,
  parameter int SLOT_W    = $clog2(KEY_SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                scan_start,
  input  logic [63:0]         key,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   wr_idx,
  input  cca_pkg::slot_word_t wr_data,
  output cca_pkg::scan_res_t  res,
  output logic [SLOT_W-1:0]   hit_idx,
  output logic [SLOT_W-1:0]   free_idx
);
  import cca_pkg::*;

  slot_word_t        mem [KEY_SLOTS];
  slot_word_t        rdata_r;
  logic [KEY_SLOTS-1:0] valid_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic              scanning_r;
  logic              cmp_v_r;
  logic              done_r;
  logic              hit_r;
  logic [SLOT_W-1:0] hit_idx_r;
  logic [12:0]       head_r;
  logic [6:0]        len_r;
  logic              free_ok;
  logic [SLOT_W-1:0] free_sel;

  // Slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rdata_r <= mem[rd_idx_r];
  end

  // Valid bits: set on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // Walk addresses and compare one slot per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      cmp_v_r    <= 1'b0;
      done_r     <= 1'b0;
      hit_r      <= 1'b0;
      rd_idx_r   <= '0;
      cmp_idx_r  <= '0;
    end else begin
      done_r  <= cmp_v_r && (cmp_idx_r == SLOT_W'(KEY_SLOTS - 1));
      cmp_v_r <= scanning_r;
      cmp_idx_r <= rd_idx_r;
      if (scan_start) begin
        scanning_r <= 1'b1;
        rd_idx_r   <= '0;
        hit_r      <= 1'b0;
      end else if (scanning_r) begin
        rd_idx_r <= rd_idx_r + SLOT_W'(1);
        if (rd_idx_r == SLOT_W'(KEY_SLOTS - 1)) begin
          scanning_r <= 1'b0;
        end
      end
      if (cmp_v_r && !hit_r && valid_r[cmp_idx_r] && (rdata_r.key == key)) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Capture the hit slot contents
  always_ff @(posedge clk) begin
    if (cmp_v_r && !hit_r && valid_r[cmp_idx_r] && (rdata_r.key == key)) begin
      hit_idx_r <= cmp_idx_r;
      head_r    <= rdata_r.head;
      len_r     <= rdata_r.len;
    end
  end

  // Lowest free slot
  always_comb begin
    free_sel = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_sel = SLOT_W'(i);
      end
    end
  end
  assign free_ok = ~&valid_r;

  assign res.done    = done_r;
  assign res.hit     = hit_r;
  assign res.free_ok = free_ok;
  assign res.head    = head_r;
  assign res.len     = len_r;
  assign hit_idx     = hit_idx_r;
  assign free_idx    = free_sel;
endmodule
`default_nettype wire

// File: rtl/core/cca_checker.sv
// ----------------------------------------------------------------------------
// cca_checker
// Port-level checks of the allocator core, bound into the core module.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chained_chunk_allocator_core_assert.svh"
module cca_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input cca_pkg::out_word_t out_data
);
  import cca_pkg::*;

  // A taken word sets busy
  `CCA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // busy is high with a non-final result and low with the final one
  `CCA_ASSERT_IMPLY(a_mid_busy, out_strobe && !out_data.last, busy)
  `CCA_ASSERT_IMPLY(a_last_idle, out_strobe && out_data.last, !busy)

  // An error status is a single chunkless result
  `CCA_ASSERT_IMPLY(a_err_single, out_strobe && (out_data.status != ST_OK),
    out_data.last && (out_data.chunk_index == 13'd0))
endmodule

bind chained_chunk_allocator_core cca_checker u_cca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);
`default_nettype wire
